FILE: hw/rtl/tps_pkg.sv
// tps_pkg: shared constants, controller states and command/status bundles
// for the triangular polyline smoother; no dependencies
package tps_pkg;

   // default build parameters
   localparam int MAX_HALF_DEFAULT   = 7;
   localparam int COORD_BITS_DEFAULT = 12;
   localparam int FRAC_BITS_DEFAULT  = 8;

   // fixed port widths
   localparam int IN_COORD_W   = 12;
   localparam int SMOOTH_W     = 20;
   localparam int HALF_WIDTH_W = 3;

   localparam logic [HALF_WIDTH_W-1:0] HALF_WIDTH_RESET = 3'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ACCUM,
      ST_DIVIDE,
      ST_OUTPUT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;         // take the request into the window
      logic accum;        // add one weighted tap
      logic div_load;     // start both dividers
      logic div_step;     // one quotient bit
      logic out_load;     // move quotients into the response register
      logic next_center;  // step to the next newer center while flushing
      logic clear_count;  // polyline finished
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic emit;      // accepted request produces at least one response
      logic tap_last;  // current tap is the last of the window
      logic div_last;  // current divide step is the last
      logic out_free;  // response register can take a value
      logic more;      // further flush responses pending
      logic flush;     // current polyline ends with this request
   } sts_type;

endpackage

FILE: hw/rtl/tps_if.sv
// tps_req_if / tps_rsp_if: valid/ready channels of the smoother
// depends on tps_pkg for payload widths
interface tps_req_if;
   logic                            valid;
   logic                            ready;
   logic [tps_pkg::IN_COORD_W-1:0]  point_x;
   logic [tps_pkg::IN_COORD_W-1:0]  point_y;
   logic                            is_last;

   modport source (output valid, output point_x, output point_y, output is_last,
                   input ready);
   modport sink   (input valid, input point_x, input point_y, input is_last,
                   output ready);
endinterface

interface tps_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [tps_pkg::SMOOTH_W-1:0]  smooth_x;
   logic [tps_pkg::SMOOTH_W-1:0]  smooth_y;
   logic                          end_of_line;

   modport source (output valid, output smooth_x, output smooth_y, output end_of_line,
                   input ready);
   modport sink   (input valid, input smooth_x, input smooth_y, input end_of_line,
                   output ready);
endinterface

FILE: hw/rtl/tps_divider.sv
// tps_divider: restoring divider, one quotient bit per step
// no package dependency
module tps_divider #(
   parameter int DVD_W = 28,
   parameter int DIV_W = 8
) (
   input  logic             clock,
   input  logic             load,
   input  logic             step,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DIV_W-1:0] divisor,
   output logic [DVD_W-1:0] quotient
);

   logic [DVD_W-1:0] q_ff, q_in;
   logic [DIV_W-1:0] r_ff, r_in;
   logic [DIV_W:0]   r_shift;
   logic [DIV_W:0]   r_diff;
   logic             ge;

   always_comb begin
      r_shift = {r_ff, q_ff[DVD_W-1]};
      ge      = (r_shift >= {1'b0, divisor});
      r_diff  = r_shift - {1'b0, divisor};
      q_in    = q_ff;
      r_in    = r_ff;
      if (load) begin
         q_in = dividend;
         r_in = '0;
      end else if (step) begin
         q_in = {q_ff[DVD_W-2:0], ge};
         r_in = ge ? r_diff[DIV_W-1:0] : r_shift[DIV_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      r_ff <= r_in;
   end

   assign quotient = q_ff;

endmodule

FILE: hw/rtl/tps_controller.sv
// tps_controller: sequencing of accept, tap accumulation, divide and output
// depends on tps_pkg for states and command/status bundles
module tps_controller (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  tps_pkg::sts_type sts,
   output tps_pkg::cmd_type cmd
);

   tps_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tps_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         tps_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (sts.emit) begin
                  state_in = tps_pkg::ST_ACCUM;
               end
            end
         end
         tps_pkg::ST_ACCUM: begin
            cmd.accum = 1'b1;
            if (sts.tap_last) begin
               cmd.div_load = 1'b1;
               state_in     = tps_pkg::ST_DIVIDE;
            end
         end
         tps_pkg::ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = tps_pkg::ST_OUTPUT;
            end
         end
         tps_pkg::ST_OUTPUT: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               if (sts.more) begin
                  cmd.next_center = 1'b1;
                  state_in        = tps_pkg::ST_ACCUM;
               end else begin
                  cmd.clear_count = sts.flush;
                  state_in        = tps_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = tps_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

FILE: hw/rtl/tps_datapath.sv
// tps_datapath: point window, weighted tap accumulation, dividers, response register
// depends on tps_pkg and tps_divider
module tps_datapath #(
   parameter  int MAX_HALF   = tps_pkg::MAX_HALF_DEFAULT,
   parameter  int COORD_BITS = tps_pkg::COORD_BITS_DEFAULT,
   parameter  int FRAC_BITS  = tps_pkg::FRAC_BITS_DEFAULT,
   localparam int H_W        = $clog2(MAX_HALF + 1)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  tps_pkg::cmd_type               cmd,
   output tps_pkg::sts_type               sts,
   input  logic [H_W-1:0]                 half_cur,
   input  logic [tps_pkg::IN_COORD_W-1:0] req_point_x,
   input  logic [tps_pkg::IN_COORD_W-1:0] req_point_y,
   input  logic                           req_is_last,
   input  logic                           rsp_ready,
   output logic                           rsp_valid,
   output logic [tps_pkg::SMOOTH_W-1:0]   rsp_smooth_x,
   output logic [tps_pkg::SMOOTH_W-1:0]   rsp_smooth_y,
   output logic                           rsp_end_of_line
);

   localparam int WIN_LEN = 2 * MAX_HALF + 1;
   localparam int K_W     = $clog2(WIN_LEN);
   localparam int AGE_W   = K_W + 1;
   localparam int CNT_W   = $clog2(WIN_LEN + 1);
   localparam int W_W     = $clog2(MAX_HALF + 2);
   localparam int DIV_W   = 2 * W_W;
   localparam int ACC_W   = COORD_BITS + DIV_W;
   localparam int DVD_W   = ACC_W + FRAC_BITS;
   localparam int STEP_W  = $clog2(DVD_W);
   localparam int PROD_W  = W_W + COORD_BITS;

   // window, newest point at index 0
   logic [COORD_BITS-1:0] store_x_ff [WIN_LEN];
   logic [COORD_BITS-1:0] store_y_ff [WIN_LEN];
   logic [COORD_BITS-1:0] store_x_in [WIN_LEN];
   logic [COORD_BITS-1:0] store_y_in [WIN_LEN];
   logic [COORD_BITS-1:0] first_x_ff, first_x_in;
   logic [COORD_BITS-1:0] first_y_ff, first_y_in;
   logic [CNT_W-1:0]      count_ff, count_in, count_inc;

   logic [H_W-1:0]        h_ff, h_in;
   logic [H_W-1:0]        c_ff, c_in, c_init;
   logic                  last_ff, last_in;
   logic [K_W-1:0]        k_ff, k_in, two_h;
   logic [DIV_W-1:0]      d_ff, d_in;
   logic [W_W-1:0]        h_plus1;

   logic [ACC_W-1:0]      acc_x_ff, acc_x_in;
   logic [ACC_W-1:0]      acc_y_ff, acc_y_in;
   logic [STEP_W-1:0]     step_ff, step_in;

   logic signed [AGE_W-1:0] age;
   logic [K_W-1:0]        age_idx;
   logic                  beyond;
   logic [COORD_BITS-1:0] tap_x, tap_y, coord_x, coord_y;
   logic [K_W:0]          wt_wide;
   logic [W_W-1:0]        wt;
   logic [PROD_W-1:0]     prod_x, prod_y;

   logic [DVD_W-1:0]      dvd_x, dvd_y, quo_x, quo_y;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [tps_pkg::SMOOTH_W-1:0]  out_x_ff, out_x_in;
   logic [tps_pkg::SMOOTH_W-1:0]  out_y_ff, out_y_in;
   logic                          eol_ff, eol_in;

   // request and window bookkeeping
   always_comb begin
      coord_x   = COORD_BITS'(req_point_x);
      coord_y   = COORD_BITS'(req_point_y);
      count_inc = (count_ff < CNT_W'(WIN_LEN)) ? count_ff + CNT_W'(1) : count_ff;
      if (req_is_last && (CNT_W'(half_cur) > count_inc - CNT_W'(1))) begin
         c_init = H_W'(count_inc - CNT_W'(1));
      end else begin
         c_init = half_cur;
      end
      h_plus1 = W_W'(half_cur) + W_W'(1);

      store_x_in = store_x_ff;
      store_y_in = store_y_ff;
      first_x_in = first_x_ff;
      first_y_in = first_y_ff;
      count_in   = count_ff;
      h_in       = h_ff;
      last_in    = last_ff;
      d_in       = d_ff;
      if (cmd.load) begin
         store_x_in[0] = coord_x;
         store_y_in[0] = coord_y;
         for (int i = 1; i < WIN_LEN; i++) begin
            store_x_in[i] = store_x_ff[i-1];
            store_y_in[i] = store_y_ff[i-1];
         end
         if (count_ff == '0) begin
            first_x_in = coord_x;
            first_y_in = coord_y;
         end
         count_in = count_inc;
         h_in     = half_cur;
         last_in  = req_is_last;
         d_in     = DIV_W'(h_plus1) * DIV_W'(h_plus1);
      end else if (cmd.clear_count) begin
         count_in = '0;
      end
   end

   // tap selection and weighting
   always_comb begin
      two_h   = K_W'({h_ff, 1'b0});
      age     = AGE_W'(c_ff) + AGE_W'(h_ff) - AGE_W'(k_ff);
      age_idx = age[AGE_W-1] ? '0 : age[K_W-1:0];
      beyond  = (CNT_W'(age_idx) >= count_ff);
      tap_x   = beyond ? first_x_ff : store_x_ff[age_idx];
      tap_y   = beyond ? first_y_ff : store_y_ff[age_idx];
      if (k_ff <= K_W'(h_ff)) begin
         wt_wide = (K_W+1)'(k_ff) + (K_W+1)'(1);
      end else begin
         wt_wide = (K_W+1)'(two_h) + (K_W+1)'(1) - (K_W+1)'(k_ff);
      end
      wt     = W_W'(wt_wide);
      prod_x = PROD_W'(wt) * PROD_W'(tap_x);
      prod_y = PROD_W'(wt) * PROD_W'(tap_y);
   end

   // sequencing counters and accumulators
   always_comb begin
      k_in     = k_ff;
      c_in     = c_ff;
      acc_x_in = acc_x_ff;
      acc_y_in = acc_y_ff;
      step_in  = step_ff;
      if (cmd.load || cmd.next_center) begin
         k_in     = '0;
         acc_x_in = '0;
         acc_y_in = '0;
         c_in     = cmd.load ? c_init : c_ff - H_W'(1);
      end else if (cmd.accum) begin
         k_in     = k_ff + K_W'(1);
         acc_x_in = acc_x_ff + ACC_W'(prod_x);
         acc_y_in = acc_y_ff + ACC_W'(prod_y);
      end
      if (cmd.div_load) begin
         step_in = '0;
      end else if (cmd.div_step) begin
         step_in = step_ff + STEP_W'(1);
      end
      dvd_x = DVD_W'(acc_x_in) << FRAC_BITS;
      dvd_y = DVD_W'(acc_y_in) << FRAC_BITS;
   end

   tps_divider #(
      .DVD_W (DVD_W),
      .DIV_W (DIV_W)
   ) u_div_x (
      .clock    (clock),
      .load     (cmd.div_load),
      .step     (cmd.div_step),
      .dividend (dvd_x),
      .divisor  (d_ff),
      .quotient (quo_x)
   );

   tps_divider #(
      .DVD_W (DVD_W),
      .DIV_W (DIV_W)
   ) u_div_y (
      .clock    (clock),
      .load     (cmd.div_load),
      .step     (cmd.div_step),
      .dividend (dvd_y),
      .divisor  (d_ff),
      .quotient (quo_y)
   );

   // response register
   always_comb begin
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      eol_in       = eol_ff;
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         out_x_in     = tps_pkg::SMOOTH_W'(quo_x);
         out_y_in     = tps_pkg::SMOOTH_W'(quo_y);
         eol_in       = last_ff && (c_ff == '0);
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_comb begin
      sts          = '0;
      sts.emit     = req_is_last || (count_inc > CNT_W'(half_cur));
      sts.tap_last = (k_ff == two_h);
      sts.div_last = (step_ff == STEP_W'(DVD_W - 1));
      sts.out_free = !rsp_valid_ff || rsp_ready;
      sts.more     = last_ff && (c_ff != '0);
      sts.flush    = last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         k_ff         <= '0;
         c_ff         <= '0;
         step_ff      <= '0;
         last_ff      <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         k_ff         <= k_in;
         c_ff         <= c_in;
         step_ff      <= step_in;
         last_ff      <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      store_x_ff <= store_x_in;
      store_y_ff <= store_y_in;
      first_x_ff <= first_x_in;
      first_y_ff <= first_y_in;
      h_ff       <= h_in;
      d_ff       <= d_in;
      acc_x_ff   <= acc_x_in;
      acc_y_ff   <= acc_y_in;
      out_x_ff   <= out_x_in;
      out_y_ff   <= out_y_in;
      eol_ff     <= eol_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_smooth_x    = out_x_ff;
   assign rsp_smooth_y    = out_y_ff;
   assign rsp_end_of_line = eol_ff;

   a_out_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("response overwritten while still pending");

   a_valid_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.out_load))
      else $error("response valid raised without an output load");

   a_first_point: assert property (@(posedge clock) disable iff (reset)
      (cmd.load && (count_ff == '0)) |=>
         (first_x_ff == store_x_ff[0]) && (first_y_ff == store_y_ff[0]))
      else $error("first point not captured at polyline start");

   a_tap_range: assert property (@(posedge clock) disable iff (reset)
      cmd.accum |-> (k_ff <= two_h))
      else $error("tap index past the window");

endmodule

FILE: hw/rtl/triangular_polyline_smoother.sv
// triangular_polyline_smoother: top level, half-width register and channel wiring
// depends on tps_pkg, tps_if, tps_controller and tps_datapath
//
// usage
//   req_bus carries polyline points (point_x, point_y) with is_last on the final
//   point; rsp_bus returns smoothed points with FRAC_BITS fraction bits (8 at the
//   defaults) and end_of_line on the last one. csr_write_en/csr_write_data set
//   the window half-width h (clamped to MAX_HALF); write it only between polylines.
// operation
//   one request at a time: the block takes a request, then for each response it
//   owes accumulates the 2h+1 window taps (one window tap per cycle), runs the
//   divide over the DVD_W quotient bits (COORD_BITS + 2*clog2(MAX_HALF+2) + FRAC_BITS,
//   28 at the defaults, one quotient bit per cycle of the shared-control restoring
//   dividers) and loads the response register once it is free. a request without a
//   response goes straight back to idle; the last request owes min(h, points-1)+1
//   responses, back to back in the same sequence.
// reset
//   synchronous, active high; clears the point count, the controller and the
//   response valid, and sets h to 2. window contents are not cleared.
// stall
//   the response sits in an output register; a stalled receiver only blocks the
//   next output load, so a new request is still taken while a response waits
module triangular_polyline_smoother #(
   parameter int MAX_HALF   = tps_pkg::MAX_HALF_DEFAULT,
   parameter int COORD_BITS = tps_pkg::COORD_BITS_DEFAULT,
   parameter int FRAC_BITS  = tps_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   tps_req_if.sink                            req_bus,
   tps_rsp_if.source                          rsp_bus,
   input  logic                               csr_write_en,
   input  logic [tps_pkg::HALF_WIDTH_W-1:0]   csr_write_data
);

   localparam int H_W = $clog2(MAX_HALF + 1);

   // half-width register as written by software
   logic [tps_pkg::HALF_WIDTH_W-1:0] half_width_ff, half_width_in;
   // clamped half-width used by the datapath
   logic [H_W-1:0]                   half_cur;

   tps_pkg::cmd_type cmd;
   tps_pkg::sts_type sts;

   always_comb begin
      half_width_in = csr_write_en ? csr_write_data : half_width_ff;
      if (int'(half_width_ff) > MAX_HALF) begin
         half_cur = H_W'(MAX_HALF);
      end else begin
         half_cur = H_W'(half_width_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_width_ff <= tps_pkg::HALF_WIDTH_RESET;
      end else begin
         half_width_ff <= half_width_in;
      end
   end

   // sequencing
   tps_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // window, accumulation, division and response register
   tps_datapath #(
      .MAX_HALF   (MAX_HALF),
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .half_cur        (half_cur),
      .req_point_x     (req_bus.point_x),
      .req_point_y     (req_bus.point_y),
      .req_is_last     (req_bus.is_last),
      .rsp_ready       (rsp_bus.ready),
      .rsp_valid       (rsp_bus.valid),
      .rsp_smooth_x    (rsp_bus.smooth_x),
      .rsp_smooth_y    (rsp_bus.smooth_y),
      .rsp_end_of_line (rsp_bus.end_of_line)
   );

endmodule

FILE: test/tb.sv
// tb: self-checking bench for triangular_polyline_smoother, streams polylines
// under several half-widths and idling patterns; depends on tps_pkg, tps_if and the rtl
module tb;

   localparam int WINDOW_DEPTH  = 2 * tps_pkg::MAX_HALF_DEFAULT + 1;
   localparam int FRAC          = tps_pkg::FRAC_BITS_DEFAULT;
   localparam int COORD_MAX     = (1 << tps_pkg::IN_COORD_W) - 1;
   localparam int SETTLE_CYCLES = 60;   // longer than one full response sequence step
   localparam int LONG_STALL    = 400;  // receiver hold-off, several responses long
   localparam int MAX_REPORTS   = 10;

   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   typedef struct packed {
      logic [tps_pkg::IN_COORD_W-1:0] x;
      logic [tps_pkg::IN_COORD_W-1:0] y;
      logic                           last;
   } point_type;

   typedef struct packed {
      logic [tps_pkg::SMOOTH_W-1:0] x;
      logic [tps_pkg::SMOOTH_W-1:0] y;
      logic                         eol;
   } smooth_type;

   logic clock;
   logic reset;
   logic csr_write_en;
   logic [tps_pkg::HALF_WIDTH_W-1:0] csr_write_data;

   tps_req_if req_bus ();
   tps_rsp_if rsp_bus ();

   triangular_polyline_smoother DUT (
      .clock          (clock),
      .reset          (reset),
      .req_bus        (req_bus),
      .rsp_bus        (rsp_bus),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   // requests still to be offered, and smoothed points still owed by the block
   point_type  points_to_send [$];
   smooth_type smoothed_due [$];

   // shadow of the smoother state
   logic [2*tps_pkg::IN_COORD_W-1:0] window_pts [WINDOW_DEPTH];
   logic [2*tps_pkg::IN_COORD_W-1:0] line_start;
   int                               line_count;
   logic [tps_pkg::HALF_WIDTH_W-1:0] shadow_half;

   // knobs set by the sequencer at the falling edge, read at the rising edge
   int send_idle_pct;
   int rsp_stall_pct;
   bit hold_input;
   int long_stall_count;

   int stall_served;
   int stall_left;
   int accepted_points;
   int mismatch_count;

   // -------------------------------------------------------------------------
   // smoothed point for the window centered at the given age
   // -------------------------------------------------------------------------
   function automatic smooth_type weigh_center(int center, int h, int count, logic eol);
      longint unsigned sum_x, sum_y, weight, divisor;
      logic [2*tps_pkg::IN_COORD_W-1:0] tap;
      smooth_type res;
      int j, age;
      sum_x = 0;
      sum_y = 0;
      for (j = -h; j <= h; j++) begin
         age = center - j;
         // younger than the newest point: replicate the last point
         if (age < 0)
            age = 0;
         // older than the polyline start: replicate the first point
         if (age >= count || age >= WINDOW_DEPTH)
            tap = line_start;
         else
            tap = window_pts[age];
         weight = 64'(h + 1 - (j < 0 ? -j : j));
         sum_x += weight * tap[tps_pkg::IN_COORD_W-1:0];
         sum_y += weight * tap[2*tps_pkg::IN_COORD_W-1:tps_pkg::IN_COORD_W];
      end
      divisor = 64'((h + 1) * (h + 1));
      res.x   = tps_pkg::SMOOTH_W'((sum_x << FRAC) / divisor);
      res.y   = tps_pkg::SMOOTH_W'((sum_y << FRAC) / divisor);
      res.eol = eol;
      return res;
   endfunction

   // -------------------------------------------------------------------------
   // shift one accepted request into the window and queue what it produces
   // -------------------------------------------------------------------------
   function automatic void take_point(point_type pt);
      logic [2*tps_pkg::IN_COORD_W-1:0] packed_pt;
      int h, i, top;
      packed_pt = {pt.y, pt.x};
      h = int'(shadow_half);
      if (h > tps_pkg::MAX_HALF_DEFAULT)
         h = tps_pkg::MAX_HALF_DEFAULT;
      if (line_count == 0)
         line_start = packed_pt;
      for (i = WINDOW_DEPTH - 1; i > 0; i--)
         window_pts[i] = window_pts[i-1];
      window_pts[0] = packed_pt;
      if (line_count < WINDOW_DEPTH)
         line_count++;
      if (!pt.last) begin
         // centre point i leaves once point i+h is in
         if (line_count > h)
            smoothed_due.insert(smoothed_due.size(),
                                weigh_center(h, h, line_count, 1'b0));
      end else begin
         // flush: every pending centre, oldest first, short polylines included
         top = (h > line_count - 1) ? line_count - 1 : h;
         for (i = top; i >= 0; i--)
            smoothed_due.insert(smoothed_due.size(),
                                weigh_center(i, h, line_count, i == 0));
         line_count = 0;
      end
   endfunction

   // -------------------------------------------------------------------------
   // clock and the run limit
   // -------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #800000;
      $display("CHECKS FAILED");
      $finish;
   end

   // -------------------------------------------------------------------------
   // request driver: offers the next queued point, unless idling, once the channel is free
   // -------------------------------------------------------------------------
   always @(posedge clock) begin : drive_points
      point_type pt;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            pt.x    = req_bus.point_x;
            pt.y    = req_bus.point_y;
            pt.last = req_bus.is_last;
            take_point(pt);
            accepted_points <= accepted_points + 1;
         end
         // a request held high stays untouched until it is taken
         if (!req_bus.valid || req_bus.ready) begin
            if (points_to_send.size() != 0 && !hold_input &&
                $urandom_range(99) >= send_idle_pct) begin
               pt = points_to_send.pop_front();
               req_bus.valid   <= 1'b1;
               req_bus.point_x <= pt.x;
               req_bus.point_y <= pt.y;
               req_bus.is_last <= pt.last;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // half-width as the block sees it
   always @(posedge clock) begin
      if (reset)
         shadow_half <= tps_pkg::HALF_WIDTH_RESET;
      else if (csr_write_en)
         shadow_half <= csr_write_data;
   end

   // -------------------------------------------------------------------------
   // receiver ready: random stalls, plus a long hold-off on request
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_served  <= 0;
         stall_left    <= 0;
      end else if (stall_served != long_stall_count) begin
         stall_served  <= long_stall_count;
         stall_left    <= LONG_STALL;
         rsp_bus.ready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left    <= stall_left - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // -------------------------------------------------------------------------
   // response monitor: each smoothed point against the oldest one owed
   // -------------------------------------------------------------------------
   always @(posedge clock) begin : check_smoothed
      smooth_type got, want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.x   = rsp_bus.smooth_x;
         got.y   = rsp_bus.smooth_y;
         got.eol = rsp_bus.end_of_line;
         if (smoothed_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("%0t: unexpected point x=%h y=%h eol=%b",
                        $realtime, got.x, got.y, got.eol);
         end else begin
            want = smoothed_due.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("%0t: exp x=%h y=%h eol=%b, got x=%h y=%h eol=%b",
                           $realtime, want.x, want.y, want.eol,
                           got.x, got.y, got.eol);
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // stimulus helpers, all called at the falling edge
   // -------------------------------------------------------------------------
   task automatic push_point(int x, int y, bit last);
      point_type pt;
      pt.x    = tps_pkg::IN_COORD_W'(x);
      pt.y    = tps_pkg::IN_COORD_W'(y);
      pt.last = last;
      points_to_send.insert(points_to_send.size(), pt);
   endtask

   // random polyline: mostly a short-step walk, sometimes scattered or pinned to the edges
   task automatic queue_polyline(int len);
      int i, cx, cy;
      bit walk;
      walk = ($urandom_range(3) != 0);
      cx   = $urandom_range(COORD_MAX);
      cy   = $urandom_range(COORD_MAX);
      for (i = 0; i < len; i++) begin
         if (walk) begin
            cx = cx + int'($urandom_range(64)) - 32;
            cy = cy + int'($urandom_range(64)) - 32;
            cx = (cx < 0) ? 0 : (cx > COORD_MAX) ? COORD_MAX : cx;
            cy = (cy < 0) ? 0 : (cy > COORD_MAX) ? COORD_MAX : cy;
         end else if ($urandom_range(7) == 0) begin
            cx = $urandom_range(1) ? COORD_MAX : 0;
            cy = $urandom_range(1) ? COORD_MAX : 0;
         end else begin
            cx = $urandom_range(COORD_MAX);
            cy = $urandom_range(COORD_MAX);
         end
         push_point(cx, cy, i == len - 1);
      end
   endtask

   // wait until everything sent has been answered, then let the block go quiet
   task automatic settle_block();
      while (points_to_send.size() != 0 || req_bus.valid || smoothed_due.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_half(logic [tps_pkg::HALF_WIDTH_W-1:0] h);
      @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= h;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      @(negedge clock);
   endtask

   // -------------------------------------------------------------------------
   // sequencer
   // -------------------------------------------------------------------------
   initial begin : sequencer
      int half_plan [10] = '{0, 7, 1, 3, 5, 6, 4, 2, 7, 0};
      idle_mode_type mode;
      int p, added, len, base;

      reset            = 1'b1;
      req_bus.valid    = 1'b0;
      req_bus.point_x  = '0;
      req_bus.point_y  = '0;
      req_bus.is_last  = 1'b0;
      rsp_bus.ready    = 1'b0;
      csr_write_en     = 1'b0;
      csr_write_data   = '0;
      send_idle_pct    = 0;
      rsp_stall_pct    = 0;
      hold_input       = 1'b0;
      long_stall_count = 0;
      accepted_points  = 0;
      mismatch_count   = 0;
      line_count       = 0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed, at the reset half-width of 2
      // one-point polyline: flushed at once with first/last replication
      push_point(COORD_MAX, 0, 1'b1);
      // two points, shorter than h+1
      push_point(0, COORD_MAX, 1'b0);
      push_point(COORD_MAX, COORD_MAX, 1'b1);
      // full window with the coordinate extremes
      push_point(0, 0, 1'b0);
      push_point(COORD_MAX, COORD_MAX, 1'b0);
      push_point(0, COORD_MAX, 1'b0);
      push_point(COORD_MAX, 0, 1'b0);
      push_point(0, 0, 1'b0);
      push_point(COORD_MAX, COORD_MAX, 1'b0);
      push_point(2048, 1365, 1'b0);
      push_point(1, 2, 1'b1);

      // widest window on a short polyline
      settle_block();
      write_half(3'd7);
      push_point(COORD_MAX, COORD_MAX, 1'b0);
      push_point(0, 0, 1'b0);
      push_point(COORD_MAX, COORD_MAX, 1'b1);

      // zero half-width: every point passes straight through
      settle_block();
      write_half(3'd0);
      push_point(COORD_MAX, 0, 1'b0);
      push_point(0, COORD_MAX, 1'b0);
      push_point(COORD_MAX, COORD_MAX, 1'b1);

      // random phases, one half-width and idling pattern each
      for (p = 0; p < 10; p++) begin
         settle_block();
         write_half(half_plan[p][2:0]);
         mode = idle_mode_type'(p % 4);
         case (mode)
            IDLE_NONE: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end
            IDLE_SENDER: begin
               send_idle_pct = 53;
               rsp_stall_pct = 0;
            end
            IDLE_RECEIVER: begin
               send_idle_pct = 0;
               rsp_stall_pct = 53;
            end
            default: begin
               send_idle_pct = 7;
               rsp_stall_pct = 7;
            end
         endcase

         added = 0;
         if (p == 4) begin
            // receiver holds off while requests keep coming, so the input backs up
            queue_polyline(24);
            added = 24;
            long_stall_count++;
         end else if (p == 6) begin
            // sender pauses mid-polyline until every owed point is out
            base = accepted_points;
            queue_polyline(24);
            added = 24;
            while (accepted_points < base + 10)
               @(negedge clock);
            hold_input = 1'b1;
            while (req_bus.valid || smoothed_due.size() != 0)
               @(negedge clock);
            repeat (20) @(negedge clock);
            hold_input = 1'b0;
         end

         while (added < 8) begin
            case ($urandom_range(9))
               0, 1:    len = $urandom_range(3, 1);
               2:       len = $urandom_range(30, 16);
               default: len = $urandom_range(12, 4);
            endcase
            queue_polyline(len);
            added += len;
         end
      end

      settle_block();
      if (mismatch_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
